// File: src/rsbm_pkg.sv
`timescale 1ns / 1ps

package rsbm_pkg;

	// Fixed formats
	localparam int SAMPLE_BITS = 24;
	localparam int MAX_BLOCK   = 4096;
	localparam int CNT_W       = 13;
	localparam int MOD_W       = 16;
	localparam int SET_W       = 13;
	localparam int GAIN_W      = 32;
	// Ramp targets in Q7.24 need 29 signed bits (level offset 17 bits, shifted by 12)
	localparam int TGT_W       = 29;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [SET_W-1:0] SET_RESET = SET_W'(4096);

	// Mixer datapath widths
	localparam int PROD_W = SAMPLE_BITS + GAIN_W;   // one lane product
	localparam int ACC_W  = PROD_W + 1;             // sum of two products
	localparam int W_W    = ACC_W - 24;             // wet sample after Q24 rounding
	localparam int D_W    = 33;                     // wet - dry, clamped to +-(2^32-1)
	localparam int TOT_W  = 66;                     // recombined split product
	localparam int R_W    = TOT_W - 24;             // rounded scaled difference
	localparam int O_W    = R_W + 1;

	localparam logic signed [ACC_W-1:0]  RND_HALF = ACC_W'(64'sd8388608);
	localparam logic signed [D_W:0]      D_MAX    = (D_W+1)'(64'sh0_FFFF_FFFF);
	localparam logic signed [D_W:0]      D_MIN    = -D_MAX;
	localparam logic signed [O_W-1:0]    S_MAX    = O_W'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
	localparam logic signed [O_W-1:0]    S_MIN    = -S_MAX - O_W'(1);
	localparam logic signed [GAIN_W:0]   G_MAX    = (GAIN_W+1)'(64'sh7FFF_FFFF);
	localparam logic signed [GAIN_W:0]   G_MIN    = -G_MAX - (GAIN_W+1)'(1);

	// Ramp register indexes
	localparam int NUM_RAMPS = 3;
	localparam int RAMP_W    = 2;
	localparam logic [RAMP_W-1:0] RAMP_DW  = 2'd0;
	localparam logic [RAMP_W-1:0] RAMP_IN  = 2'd1;
	localparam logic [RAMP_W-1:0] RAMP_BUS = 2'd2;

	// Command queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Serial divider: magnitude of (target - now) over the frame count
	localparam int DIV_N_W   = GAIN_W;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	typedef enum logic {
		OP_PREP  = 1'b0,
		OP_FRAME = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_DRYWET  = 2'd0,
		REG_IN_LVL  = 2'd1,
		REG_BUS_LVL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		op_t                            op;
		logic [CNT_W-1:0]               count;
		logic signed [TGT_W-1:0]        t_dw;
		logic signed [TGT_W-1:0]        t_in;
		logic signed [TGT_W-1:0]        t_bus;
		logic signed [SAMPLE_BITS-1:0]  in_l;
		logic signed [SAMPLE_BITS-1:0]  in_r;
		logic signed [SAMPLE_BITS-1:0]  bus_l;
		logic signed [SAMPLE_BITS-1:0]  bus_r;
	} cmd_t;

	typedef struct packed {
		logic                     start;
		logic signed [GAIN_W:0]   dividend;
		logic [CNT_W-1:0]         divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [GAIN_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL_IN,
		ST_MUL_BUS,
		ST_SUM,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FIN,
		ST_OUT
	} back_state_t;

endpackage

// File: src/rsbm_if.sv
`timescale 1ns / 1ps

// Command channel: prepare and frame beats
interface rsbm_cmd_if;
	import rsbm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [CNT_W-1:0]               frame_count;
	logic signed [MOD_W-1:0]        mod_mix;
	logic signed [MOD_W-1:0]        mod_input_level;
	logic signed [MOD_W-1:0]        mod_bus_level;
	logic signed [SAMPLE_BITS-1:0]  in_left;
	logic signed [SAMPLE_BITS-1:0]  in_right;
	logic signed [SAMPLE_BITS-1:0]  bus_left;
	logic signed [SAMPLE_BITS-1:0]  bus_right;

	modport source (
		output valid, opcode, frame_count, mod_mix, mod_input_level, mod_bus_level,
		output in_left, in_right, bus_left, bus_right,
		input  ready
	);

	modport sink (
		input  valid, opcode, frame_count, mod_mix, mod_input_level, mod_bus_level,
		input  in_left, in_right, bus_left, bus_right,
		output ready
	);
endinterface

// Mixed stereo result channel
interface rsbm_mix_if;
	import rsbm_pkg::*;

	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_BITS-1:0]  out_left;
	logic signed [SAMPLE_BITS-1:0]  out_right;

	modport source (output valid, out_left, out_right, input ready);
	modport sink (input valid, out_left, out_right, output ready);
endinterface

// File: src/rsbm_front.sv
`timescale 1ns / 1ps

module rsbm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [rsbm_pkg::DATA_W-1:0]   pwdata,
	output logic [rsbm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	rsbm_cmd_if.sink                      cmd,
	output logic                          push,
	output rsbm_pkg::cmd_t                push_data,
	input  logic                          full
);
	import rsbm_pkg::*;

	logic [SET_W-1:0] drywet_q;
	logic [SET_W-1:0] in_lvl_q;
	logic [SET_W-1:0] bus_lvl_q;

	logic              wr_en;
	reg_idx_t          reg_idx;
	logic signed [17:0] dw_sum;
	logic [SET_W-1:0]  dw_clamped;
	logic signed [17:0] lvl_in;
	logic signed [17:0] lvl_bus;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	// Setting registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drywet_q  <= SET_RESET;
			in_lvl_q  <= SET_RESET;
			bus_lvl_q <= SET_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DRYWET:  drywet_q  <= pwdata[SET_W-1:0];
				REG_IN_LVL:  in_lvl_q  <= pwdata[SET_W-1:0];
				REG_BUS_LVL: bus_lvl_q <= pwdata[SET_W-1:0];
				default: ;
			endcase
		end
	end

	// Readback
	always_comb begin
		unique case (reg_idx)
			REG_DRYWET:  prdata = DATA_W'(drywet_q);
			REG_IN_LVL:  prdata = DATA_W'(in_lvl_q);
			REG_BUS_LVL: prdata = DATA_W'(bus_lvl_q);
			default:     prdata = '0;
		endcase
	end

	// Dry/wet target: setting + offset, clamped to 0..1
	assign dw_sum = $signed({5'b0, drywet_q}) + 18'(cmd.mod_mix);
	always_comb begin
		if (dw_sum < 18'sd0)
			dw_clamped = '0;
		else if (dw_sum > 18'sd4096)
			dw_clamped = SET_W'(4096);
		else
			dw_clamped = dw_sum[SET_W-1:0];
	end

	// Level targets: (setting - 0.5) * 2 + offset, always within 17 signed bits
	assign lvl_in  = $signed({4'b0, in_lvl_q, 1'b0}) - 18'sd4096 + 18'(cmd.mod_input_level);
	assign lvl_bus = $signed({4'b0, bus_lvl_q, 1'b0}) - 18'sd4096 + 18'(cmd.mod_bus_level);

	// Classify and queue the beat
	assign cmd.ready = !full;
	assign push      = cmd.valid && !full;

	always_comb begin
		push_data.op    = op_t'(cmd.opcode);
		push_data.count = (cmd.frame_count > CNT_W'(MAX_BLOCK)) ?
			CNT_W'(MAX_BLOCK) : cmd.frame_count;
		push_data.t_dw  = $signed({4'b0, dw_clamped, 12'b0});
		push_data.t_in  = $signed({lvl_in[16:0], 12'b0});
		push_data.t_bus = $signed({lvl_bus[16:0], 12'b0});
		push_data.in_l  = cmd.in_left;
		push_data.in_r  = cmd.in_right;
		push_data.bus_l = cmd.bus_left;
		push_data.bus_r = cmd.bus_right;
	end

endmodule

// File: src/rsbm_fifo.sv
`timescale 1ns / 1ps

module rsbm_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rsbm_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output rsbm_pkg::cmd_t  head,
	output logic            empty
);
	import rsbm_pkg::*;

	cmd_t                 mem [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

endmodule

// File: src/rsbm_div.sv
`timescale 1ns / 1ps

module rsbm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rsbm_pkg::div_req_t  req,
	output rsbm_pkg::div_rsp_t  rsp
);
	import rsbm_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]      rem_q;
	logic [DIV_N_W-1:0]    num_q;
	logic [CNT_W-1:0]      den_q;
	logic                  neg_q;
	logic signed [GAIN_W-1:0] quo_q;

	logic [GAIN_W:0]       mag;
	logic [CNT_W:0]        trial;
	logic                  ge;
	logic [DIV_N_W-1:0]    num_next;
	logic [GAIN_W:0]       q_ext;
	logic signed [GAIN_W-1:0] q_sat;

	assign mag = req.dividend[GAIN_W] ? (GAIN_W+1)'(-req.dividend) : req.dividend;

	// One quotient bit per cycle, restoring form
	assign trial    = {rem_q, num_q[DIV_N_W-1]};
	assign ge       = (trial >= {1'b0, den_q});
	assign num_next = {num_q[DIV_N_W-2:0], ge};
	assign q_ext    = {1'b0, num_next};

	// Truncated quotient, saturated to 32 bits signed
	always_comb begin
		if (neg_q)
			q_sat = (q_ext > (GAIN_W+1)'(-G_MIN)) ? GAIN_W'(G_MIN) : GAIN_W'(-q_ext);
		else
			q_sat = (q_ext > (GAIN_W+1)'(G_MAX)) ? GAIN_W'(G_MAX) : GAIN_W'(q_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= mag[DIV_N_W-1:0];
			den_q <= req.divisor;
			neg_q <= req.dividend[GAIN_W];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			num_q <= num_next;
			if (cnt_q == DIV_CNT_W'(DIV_N_W - 1))
				quo_q <= q_sat;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// File: src/rsbm_back.sv
`timescale 1ns / 1ps

module rsbm_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsbm_pkg::cmd_t      head,
	input  logic                empty,
	output logic                pop,
	output rsbm_pkg::div_req_t  div_req,
	input  rsbm_pkg::div_rsp_t  div_rsp,
	rsbm_mix_if.source          mix
);
	import rsbm_pkg::*;

	back_state_t st_q, st_d;
	logic [RAMP_W-1:0] idx_q, idx_d;

	// Ramp state, Q7.24
	logic signed [GAIN_W-1:0] now_q  [NUM_RAMPS];
	logic signed [GAIN_W-1:0] step_q [NUM_RAMPS];
	logic signed [GAIN_W-1:0] now_adv [NUM_RAMPS];
	logic signed [GAIN_W:0]   now_sum [NUM_RAMPS];
	logic signed [TGT_W-1:0]  tgt [NUM_RAMPS];

	// Per-lane mixer datapath (0 = left, 1 = right)
	logic signed [SAMPLE_BITS-1:0] smp_in  [2];
	logic signed [SAMPLE_BITS-1:0] smp_bus [2];
	logic signed [SAMPLE_BITS-1:0] mul_a   [2];
	logic signed [GAIN_W-1:0]      mul_b   [2];
	logic signed [PROD_W-1:0]      mul_p   [2];
	logic signed [PROD_W-1:0]      prod_q  [2];
	logic signed [ACC_W-1:0]       acc_q   [2];
	logic signed [ACC_W-1:0]       sum     [2];
	logic signed [W_W-1:0]         w_q     [2];
	logic signed [D_W:0]           dd      [2];
	logic signed [D_W-1:0]         d_q     [2];
	logic signed [TOT_W-1:0]       tot     [2];
	logic signed [R_W-1:0]         r_q     [2];
	logic signed [O_W-1:0]         o_full  [2];
	logic signed [SAMPLE_BITS-1:0] o_sat   [2];

	logic snap, step_wr, out_load, out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;

	assign tgt[RAMP_DW]  = head.t_dw;
	assign tgt[RAMP_IN]  = head.t_in;
	assign tgt[RAMP_BUS] = head.t_bus;
	assign smp_in[0]  = head.in_l;
	assign smp_in[1]  = head.in_r;
	assign smp_bus[0] = head.bus_l;
	assign smp_bus[1] = head.bus_r;

	// Ramp advance with 32-bit saturation
	always_comb begin
		for (int r = 0; r < NUM_RAMPS; r++) begin
			now_sum[r] = (GAIN_W+1)'(now_q[r]) + (GAIN_W+1)'(step_q[r]);
			if (now_sum[r] > G_MAX)
				now_adv[r] = GAIN_W'(G_MAX);
			else if (now_sum[r] < G_MIN)
				now_adv[r] = GAIN_W'(G_MIN);
			else
				now_adv[r] = GAIN_W'(now_sum[r]);
		end
	end

	// Divider request for the ramp under work
	assign div_req.start    = (st_q == ST_DIV_GO);
	assign div_req.dividend = (GAIN_W+1)'(tgt[idx_q]) - (GAIN_W+1)'(now_q[idx_q]);
	assign div_req.divisor  = head.count;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			idx_q <= RAMP_DW;
		end else begin
			st_q  <= st_d;
			idx_q <= idx_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		idx_d    = idx_q;
		pop      = 1'b0;
		snap     = 1'b0;
		step_wr  = 1'b0;
		out_load = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (!empty) begin
					if (head.op == OP_FRAME) begin
						st_d = ST_MUL_IN;
					end else if (head.count == '0) begin
						snap = 1'b1;
						pop  = 1'b1;
					end else begin
						idx_d = RAMP_DW;
						st_d  = ST_DIV_GO;
					end
				end
			end
			ST_DIV_GO:   st_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					step_wr = 1'b1;
					if (idx_q == RAMP_BUS) begin
						pop  = 1'b1;
						st_d = ST_IDLE;
					end else begin
						idx_d = idx_q + RAMP_W'(1);
						st_d  = ST_DIV_GO;
					end
				end
			end
			ST_MUL_IN:  st_d = ST_MUL_BUS;
			ST_MUL_BUS: st_d = ST_SUM;
			ST_SUM:     st_d = ST_DIFF;
			ST_DIFF:    st_d = ST_MUL_LO;
			ST_MUL_LO:  st_d = ST_MUL_HI;
			ST_MUL_HI:  st_d = ST_FIN;
			ST_FIN:     st_d = ST_OUT;
			ST_OUT: begin
				if (!out_vld_q || mix.ready) begin
					out_load = 1'b1;
					pop      = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Ramp registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_RAMPS; r++) begin
				now_q[r]  <= '0;
				step_q[r] <= '0;
			end
		end else begin
			if (snap) begin
				for (int r = 0; r < NUM_RAMPS; r++) begin
					now_q[r]  <= GAIN_W'(tgt[r]);
					step_q[r] <= '0;
				end
			end
			if (step_wr)
				step_q[idx_q] <= div_rsp.quotient;
			if (out_load) begin
				for (int r = 0; r < NUM_RAMPS; r++)
					now_q[r] <= now_adv[r];
			end
		end
	end

	// Lane multiplier operands; the difference is split 17 + 16 bits
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			unique case (st_q)
				ST_MUL_BUS: begin
					mul_a[l] = smp_bus[l];
					mul_b[l] = now_q[RAMP_BUS];
				end
				ST_MUL_LO: begin
					mul_a[l] = $signed({8'b0, d_q[l][15:0]});
					mul_b[l] = now_q[RAMP_DW];
				end
				ST_MUL_HI: begin
					mul_a[l] = SAMPLE_BITS'($signed(d_q[l][D_W-1:16]));
					mul_b[l] = now_q[RAMP_DW];
				end
				default: begin
					mul_a[l] = smp_in[l];
					mul_b[l] = now_q[RAMP_IN];
				end
			endcase
			mul_p[l] = PROD_W'(mul_a[l]) * PROD_W'(mul_b[l]);
		end
	end

	// Datapath arithmetic between stages
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			sum[l] = acc_q[l] + ACC_W'(prod_q[l]);
			dd[l]  = (D_W+1)'(w_q[l]) - (D_W+1)'(smp_in[l]);
			tot[l] = (TOT_W'(prod_q[l]) <<< 16) + TOT_W'(acc_q[l]);
			o_full[l] = O_W'(smp_in[l]) + O_W'(r_q[l]);
			if (o_full[l] > S_MAX)
				o_sat[l] = SAMPLE_BITS'(S_MAX);
			else if (o_full[l] < S_MIN)
				o_sat[l] = SAMPLE_BITS'(S_MIN);
			else
				o_sat[l] = SAMPLE_BITS'(o_full[l]);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			unique case (st_q)
				ST_MUL_IN: prod_q[l] <= mul_p[l];
				ST_MUL_BUS, ST_MUL_HI: begin
					// rounding half folded into the first partial term
					acc_q[l]  <= ACC_W'(prod_q[l]) + RND_HALF;
					prod_q[l] <= mul_p[l];
				end
				ST_SUM: w_q[l] <= sum[l][ACC_W-1:24];
				ST_DIFF: begin
					if (dd[l] > D_MAX)
						d_q[l] <= D_W'(D_MAX);
					else if (dd[l] < D_MIN)
						d_q[l] <= D_W'(D_MIN);
					else
						d_q[l] <= D_W'(dd[l]);
				end
				ST_MUL_LO: prod_q[l] <= mul_p[l];
				ST_FIN:    r_q[l] <= tot[l][TOT_W-1:24];
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (out_load)
			out_vld_q <= 1'b1;
		else if (mix.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_l_q <= o_sat[0];
			out_r_q <= o_sat[1];
		end
	end

	assign mix.valid     = out_vld_q;
	assign mix.out_left  = out_l_q;
	assign mix.out_right = out_r_q;

endmodule

// File: src/ramped_stereo_bus_mixer_top.sv
`timescale 1ns / 1ps

// Stereo dry/wet mixer with linear gain ramps. A prepare beat (opcode 0) sets
// new ramp targets from the three setting registers plus its modulation
// offsets; a frame beat (opcode 1) returns one saturated stereo pair and then
// steps the ramps. The front takes beats into a two-entry command queue; the
// beat under work keeps its entry until it is done, so one more beat is
// accepted while the back is busy, and two once a result waits at the output.
// Back sequence: a frame runs the four multiplies per channel through one
// 24x32 multiplier per lane and may wait in ST_OUT until the output is free;
// a prepare with a zero frame count snaps the ramps to their targets from
// ST_IDLE; a prepare with a nonzero count runs the serial divider for the
// three ramps in turn (a start, one divide step per quotient bit, then done).
// Registers sit at byte addresses 0 (dry/wet), 4 (input level), 8 (bus level).

module ramped_stereo_bus_mixer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rsbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [rsbm_pkg::DATA_W-1:0]   pwdata,
	output logic [rsbm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	rsbm_cmd_if.sink                      cmd,
	rsbm_mix_if.source                    mix
);
	import rsbm_pkg::*;

	logic     push, full, pop, empty;
	cmd_t     push_data, head;
	div_req_t div_req;
	div_rsp_t div_rsp;

	rsbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	rsbm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	rsbm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rsbm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.mix     (mix)
	);

endmodule
